// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TWS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TWS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants, types and helpers of the textured wall column shader.
// ----------------------------------------------------------------------------
package tws_pkg;

	// Scene geometry.
	localparam int CELL_SIZE     = 64;
	localparam int SCREEN_HEIGHT = 512;
	localparam int SCREEN_WIDTH  = 1024;
	localparam int RAY_COUNT     = 256;
	localparam int TEX_DIM       = 64;

	// Fixed point: 8 fraction bits.
	localparam int FRAC = 8;

	// Word field widths.
	localparam int DIST_W  = 20;
	localparam int HIT_W   = 12;
	localparam int RAY_W   = 8;
	localparam int COFF_W  = 3;
	localparam int ROW_W   = 9;
	localparam int SIDE_W  = 2;
	localparam int LCOL_W  = 6;
	localparam int LROW_W  = 6;
	localparam int COLOR_W = 32;
	localparam int PX_W    = 11;

	// Configuration registers.
	localparam int CFG_W           = 7;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_HEIGHT_BASE = 4;
	localparam int CFG_RESET       = 64;

	// Derived widths.
	localparam int CELL_W      = $clog2(CELL_SIZE);
	localparam int TEX_W       = $clog2(TEX_DIM);
	localparam int STORE_DEPTH = 4 * TEX_DIM * TEX_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// Slice height divider: lh = (CELL_SIZE*SCREEN_HEIGHT << 2*FRAC) / dist.
	localparam longint unsigned LH_NUM =
		(longint'(CELL_SIZE) * longint'(SCREEN_HEIGHT)) << (2 * FRAC);
	localparam int LH_W   = $clog2(LH_NUM + 1);
	localparam longint unsigned LH_MIN = LH_NUM / ((longint'(1) << DIST_W) - 1);

	// Step divider: step = (tex_height << 2*FRAC) / lh, bounded by the smallest lh.
	localparam int NUM_W  = CFG_W + 2 * FRAC;
	localparam int STEP_W = $clog2(((longint'(1) << NUM_W) - 1) / LH_MIN + 1);

	// Window geometry.
	localparam int FULL_H = SCREEN_HEIGHT << FRAC;
	localparam int HC_W   = $clog2(FULL_H + 1);
	localparam int SOFF_W = LH_W - 1;
	localparam int Y_W    = $clog2(SCREEN_HEIGHT) + 1;
	localparam int PA_W   = SOFF_W + STEP_W;
	localparam int PB_W   = Y_W + STEP_W;
	localparam int IV_W   = PA_W - FRAC + 1;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_SHADE = 1'b1
	} op_t;

	typedef enum logic [SIDE_W-1:0] {
		SIDE_NORTH = 2'd0,
		SIDE_SOUTH = 2'd1,
		SIDE_WEST  = 2'd2,
		SIDE_EAST  = 2'd3
	} side_t;

	// Item context that rides along the pipeline.
	typedef struct packed {
		op_t                  op;
		side_t                side;
		logic [CELL_W-1:0]    hit_c;
		logic [PX_W-1:0]      pix_x;
		logic [ROW_W-1:0]     row;
		logic [SIDE_W-1:0]    load_side;
		logic [LCOL_W-1:0]    load_col;
		logic [LROW_W-1:0]    load_row;
		logic [COLOR_W-1:0]   load_value;
	} ctx_t;

	// Slice geometry once the height is known.
	typedef struct packed {
		ctx_t                 ctx;
		logic [CFG_W-1:0]     th;
		logic [SOFF_W-1:0]    soff;
		logic [Y_W-1:0]       y0;
		logic [Y_W-1:0]       y1;
	} geo_t;

	typedef struct packed {
		logic [PX_W-1:0]      pixel_x;
		logic [ROW_W-1:0]     pixel_y;
		logic                 on_wall;
		logic [COLOR_W-1:0]   color;
	} res_t;

	// Clamp a texel index to min(size, TEX_DIM) - 1, a size of zero counting as one.
	function automatic logic [TEX_W-1:0] sat_idx(input logic [31:0] v,
			input logic [CFG_W-1:0] size);
		logic [31:0] lim;
		lim = (size == '0) ? 32'd1 : 32'(size);
		if (lim > 32'(TEX_DIM)) begin
			lim = 32'(TEX_DIM);
		end
		return (v >= lim) ? TEX_W'(lim - 32'd1) : TEX_W'(v);
	endfunction

endpackage

// ===== src/tws_in_if.sv =====
// ----------------------------------------------------------------------------
// tws_in_if
// Input channel: load and shade words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tws_in_if;
	import tws_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [DIST_W-1:0]   ray_distance;
	logic [SIDE_W-1:0]   wall_side;
	logic [HIT_W-1:0]    hit_coord;
	logic [RAY_W-1:0]    ray_num;
	logic [COFF_W-1:0]   column_offset;
	logic [ROW_W-1:0]    screen_row;
	logic [SIDE_W-1:0]   load_side;
	logic [LCOL_W-1:0]   load_col;
	logic [LROW_W-1:0]   load_row;
	logic [COLOR_W-1:0]  load_value;

	modport source (output valid, op, ray_distance, wall_side, hit_coord, ray_num,
		column_offset, screen_row, load_side, load_col, load_row, load_value,
		input ready);
	modport sink (input valid, op, ray_distance, wall_side, hit_coord, ray_num,
		column_offset, screen_row, load_side, load_col, load_row, load_value,
		output ready);
endinterface

// ===== src/tws_out_if.sv =====
// ----------------------------------------------------------------------------
// tws_out_if
// Output channel: shaded pixel words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tws_out_if;
	import tws_pkg::*;

	logic                valid;
	logic                ready;
	logic [PX_W-1:0]     pixel_x;
	logic [ROW_W-1:0]    pixel_y;
	logic                on_wall;
	logic [COLOR_W-1:0]  color;

	modport source (output valid, pixel_x, pixel_y, on_wall, color, input ready);
	modport sink (input valid, pixel_x, pixel_y, on_wall, color, output ready);
endinterface

// ===== src/tws_ram.sv =====
// ----------------------------------------------------------------------------
// tws_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/tws_lh_div.sv =====
// ----------------------------------------------------------------------------
// tws_lh_div
// Pipelined restoring divider for the slice height, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tws_lh_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [tws_pkg::DIST_W-1:0]  in_dist,
	input  tws_pkg::ctx_t               in_ctx,
	output logic                        out_valid,
	output logic [tws_pkg::LH_W-1:0]    out_lh,
	output tws_pkg::ctx_t               out_ctx
);
	import tws_pkg::*;

	localparam int SW = LH_W + DIST_W;

	logic [LH_W-1:0]   rem_s  [LH_W];
	logic [LH_W-1:0]   quo_s  [LH_W];
	logic [DIST_W-1:0] dist_s [LH_W];
	ctx_t              ctx_s  [LH_W];
	logic              v_s    [LH_W];

	for (genvar k = 0; k < LH_W; k++) begin : g_stage
		localparam int B = LH_W - 1 - k;
		logic [LH_W-1:0]   rem_i;
		logic [LH_W-1:0]   quo_i;
		logic [DIST_W-1:0] dist_i;
		ctx_t              ctx_i;
		logic              v_i;
		logic [SW-1:0]     sh;
		logic              fit;

		if (k == 0) begin : g_first
			assign rem_i  = LH_W'(LH_NUM);
			assign quo_i  = '0;
			assign dist_i = in_dist;
			assign ctx_i  = in_ctx;
			assign v_i    = in_valid;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign dist_i = dist_s[k-1];
			assign ctx_i  = ctx_s[k-1];
			assign v_i    = v_s[k-1];
		end

		assign sh  = SW'(dist_i) << B;
		assign fit = SW'(rem_i) >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= fit ? (rem_i - sh[LH_W-1:0]) : rem_i;
				quo_s[k]  <= fit ? (quo_i | (LH_W'(1) << B)) : quo_i;
				dist_s[k] <= dist_i;
				ctx_s[k]  <= ctx_i;
			end
		end
	end

	assign out_valid = v_s[LH_W-1];
	assign out_lh    = quo_s[LH_W-1];
	assign out_ctx   = ctx_s[LH_W-1];
endmodule

// ===== src/tws_step_div.sv =====
// ----------------------------------------------------------------------------
// tws_step_div
// Pipelined restoring divider for the vertical texture step.
// ----------------------------------------------------------------------------
module tws_step_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [tws_pkg::NUM_W-1:0]   in_num,
	input  logic [tws_pkg::LH_W-1:0]    in_lh,
	input  tws_pkg::geo_t               in_geo,
	output logic                        out_valid,
	output logic [tws_pkg::STEP_W-1:0]  out_step,
	output tws_pkg::geo_t               out_geo
);
	import tws_pkg::*;

	localparam int SW = LH_W + STEP_W;

	// The smallest possible height keeps the quotient within STEP_W bits.
	logic [NUM_W-1:0]  rem_s [STEP_W];
	logic [STEP_W-1:0] quo_s [STEP_W];
	logic [LH_W-1:0]   lh_s  [STEP_W];
	geo_t              geo_s [STEP_W];
	logic              v_s   [STEP_W];

	for (genvar k = 0; k < STEP_W; k++) begin : g_stage
		localparam int B = STEP_W - 1 - k;
		logic [NUM_W-1:0]  rem_i;
		logic [STEP_W-1:0] quo_i;
		logic [LH_W-1:0]   lh_i;
		geo_t              geo_i;
		logic              v_i;
		logic [SW-1:0]     sh;
		logic              fit;

		if (k == 0) begin : g_first
			assign rem_i = in_num;
			assign quo_i = '0;
			assign lh_i  = in_lh;
			assign geo_i = in_geo;
			assign v_i   = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign quo_i = quo_s[k-1];
			assign lh_i  = lh_s[k-1];
			assign geo_i = geo_s[k-1];
			assign v_i   = v_s[k-1];
		end

		assign sh  = SW'(lh_i) << B;
		assign fit = SW'(rem_i) >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= fit ? (rem_i - sh[NUM_W-1:0]) : rem_i;
				quo_s[k] <= fit ? (quo_i | (STEP_W'(1) << B)) : quo_i;
				lh_s[k]  <= lh_i;
				geo_s[k] <= geo_i;
			end
		end
	end

	assign out_valid = v_s[STEP_W-1];
	assign out_step  = quo_s[STEP_W-1];
	assign out_geo   = geo_s[STEP_W-1];
endmodule

// ===== src/textured_wall_column_shader.sv =====
// ----------------------------------------------------------------------------
// textured_wall_column_shader
// Pipeline: 32 height divider stages, 12 step divider stages, 3 shading stages
// and an output register lie between an accepted word and its result word.
// Throughput: one word per cycle while the skid register is empty; the rate
// is set by the one-bit-per-stage dividers, each stage taking a new word every cycle.
// Reset: arst_n clears all valid bits and sets every size register to 64; the
// texture store holds undefined data until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module textured_wall_column_shader (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tws_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tws_pkg::CFG_W-1:0]       cfg_data,
	tws_in_if.sink                          in_ch,
	tws_out_if.source                       out_ch
);
	import tws_pkg::*;

	// The whole pipeline moves on one advance signal. It only stops when the
	// skid register is occupied, so the block keeps taking words while the
	// output register waits for the sink.
	logic adv;

	// ------------------------------------------------------------------
	// Size registers: texture widths and heights, one per wall side.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] width_q  [4];
	logic [CFG_W-1:0] height_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				width_q[i]  <= CFG_W'(CFG_RESET);
				height_q[i] <= CFG_W'(CFG_RESET);
			end
		end else if (cfg_we) begin
			if (cfg_idx < CFG_IDX_W'(CFG_HEIGHT_BASE)) begin
				width_q[cfg_idx[1:0]] <= cfg_data;
			end else begin
				height_q[cfg_idx[1:0]] <= cfg_data;
			end
		end
	end

	// ------------------------------------------------------------------
	// Entry: build the context. A zero distance is treated as 1/256, and the
	// screen column is fixed here since it depends on nothing downstream.
	// ------------------------------------------------------------------
	ctx_t              in_ctx;
	logic [DIST_W-1:0] in_dist;
	logic [31:0]       px_full;

	assign px_full = 32'(in_ch.ray_num) * SCREEN_WIDTH / RAY_COUNT
		+ 32'(in_ch.column_offset);

	always_comb begin
		in_ctx.op         = op_t'(in_ch.op);
		in_ctx.side       = side_t'(in_ch.wall_side);
		in_ctx.hit_c      = in_ch.hit_coord[CELL_W-1:0];
		in_ctx.pix_x      = px_full[PX_W-1:0];
		in_ctx.row        = in_ch.screen_row;
		in_ctx.load_side  = in_ch.load_side;
		in_ctx.load_col   = in_ch.load_col;
		in_ctx.load_row   = in_ch.load_row;
		in_ctx.load_value = in_ch.load_value;
	end

	assign in_dist     = (in_ch.ray_distance == '0) ? DIST_W'(1) : in_ch.ray_distance;
	assign in_ch.ready = adv;

	// ------------------------------------------------------------------
	// Slice height: lh = 2^31 / dist, one quotient bit per stage.
	// ------------------------------------------------------------------
	logic            lh_valid;
	logic [LH_W-1:0] lh;
	ctx_t            lh_ctx;

	tws_lh_div u_lh_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_ch.valid),
		.in_dist   (in_dist),
		.in_ctx    (in_ctx),
		.out_valid (lh_valid),
		.out_lh    (lh),
		.out_ctx   (lh_ctx)
	);

	// ------------------------------------------------------------------
	// Window geometry. When the slice is taller than the screen, the part
	// cut off above the top becomes a start offset into the texture and the
	// height is clamped. The step divider below still uses the full height.
	// ------------------------------------------------------------------
	logic              big;
	logic [HC_W-1:0]   lhc;
	logic [HC_W-1:0]   loff;
	logic [HC_W:0]     lsum;
	geo_t              geo_in;
	logic [CFG_W-1:0]  th;

	assign big  = lh > LH_W'(FULL_H);
	assign lhc  = big ? HC_W'(FULL_H) : HC_W'(lh);
	assign loff = HC_W'(FULL_H >> 1) - (lhc >> 1);
	assign lsum = (HC_W + 1)'(lhc) + (HC_W + 1)'(loff);
	assign th   = height_q[lh_ctx.side];

	always_comb begin
		geo_in.ctx  = lh_ctx;
		geo_in.th   = th;
		geo_in.soff = big ? SOFF_W'((lh - LH_W'(FULL_H)) >> 1) : '0;
		geo_in.y0   = Y_W'(1) + Y_W'(loff >> FRAC);
		geo_in.y1   = Y_W'(1) + Y_W'(lsum >> FRAC);
	end

	// ------------------------------------------------------------------
	// Texture step: (tex_height << 16) / lh.
	// ------------------------------------------------------------------
	logic              st_valid;
	logic [STEP_W-1:0] step;
	geo_t              st_geo;

	tws_step_div u_step_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (lh_valid),
		.in_num    ({th, {(2 * FRAC){1'b0}}}),
		.in_lh     (lh),
		.in_geo    (geo_in),
		.out_valid (st_valid),
		.out_step  (step),
		.out_geo   (st_geo)
	);

	// ------------------------------------------------------------------
	// Stage 1: wall test and the two step products.
	// ------------------------------------------------------------------
	logic           v_s1;
	geo_t           geo_s1;
	logic           on_s1;
	logic [PA_W-1:0] pa_s1;
	logic [PB_W-1:0] pb_s1;
	logic [Y_W-1:0]  row_y;

	assign row_y = Y_W'(st_geo.ctx.row);

	// ------------------------------------------------------------------
	// Stage 2: texture coordinate sum.
	// ------------------------------------------------------------------
	logic            v_s2;
	geo_t            geo_s2;
	logic            on_s2;
	logic [IV_W-1:0] iv_s2;

	// ------------------------------------------------------------------
	// Stage 3: texel fetch result aligned with its context.
	// ------------------------------------------------------------------
	logic v_s3;
	ctx_t ctx_s3;
	logic on_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= st_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1 <= st_geo;
			on_s1  <= (row_y >= st_geo.y0) && (row_y <= st_geo.y1);
			pa_s1  <= PA_W'(st_geo.soff) * PA_W'(step);
			pb_s1  <= PB_W'(row_y - st_geo.y0) * PB_W'(step);

			geo_s2 <= geo_s1;
			on_s2  <= on_s1;
			iv_s2  <= IV_W'(1 << FRAC) + IV_W'(pa_s1 >> FRAC) + IV_W'(pb_s1);

			ctx_s3 <= geo_s2.ctx;
			on_s3  <= on_s2;
		end
	end

	// Texel address from stage 2. South and west walls are seen from behind,
	// so their texture column runs mirrored.
	logic [CELL_W-1:0]        hc;
	logic [CELL_W+CFG_W-1:0]  cprod;
	logic [TEX_W-1:0]         tcol;
	logic [TEX_W-1:0]         trow;
	logic [CFG_W-1:0]         tw;
	logic [ADDR_W-1:0]        raddr;
	logic [ADDR_W-1:0]        waddr;
	logic                     we;
	logic [COLOR_W-1:0]       rdata;

	assign tw    = width_q[geo_s2.ctx.side];
	assign hc    = (geo_s2.ctx.side == SIDE_SOUTH || geo_s2.ctx.side == SIDE_WEST)
		? ~geo_s2.ctx.hit_c : geo_s2.ctx.hit_c;
	assign cprod = (CELL_W + CFG_W)'(hc) * (CELL_W + CFG_W)'(tw);
	assign tcol  = sat_idx(32'(cprod >> CELL_W), tw);
	assign trow  = sat_idx(32'(iv_s2 >> FRAC), geo_s2.th);
	assign raddr = {geo_s2.ctx.side, tcol, trow};

	// Loads write at the same stage where shades read, so a shade that follows
	// a load always sees the new texel.
	assign waddr = {geo_s2.ctx.load_side, geo_s2.ctx.load_col[TEX_W-1:0],
		geo_s2.ctx.load_row[TEX_W-1:0]};
	assign we    = adv && v_s2 && (geo_s2.ctx.op == OP_LOAD)
		&& (32'(geo_s2.ctx.load_col) < 32'(TEX_DIM))
		&& (32'(geo_s2.ctx.load_row) < 32'(TEX_DIM));

	tws_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (geo_s2.ctx.load_value),
		.re    (adv),
		.raddr (raddr),
		.rdata (rdata)
	);

	// ------------------------------------------------------------------
	// Result word. Loads answer with all fields zero; off-wall rows carry a
	// zero color.
	// ------------------------------------------------------------------
	res_t res_s3;

	always_comb begin
		res_s3 = '0;
		if (ctx_s3.op == OP_SHADE) begin
			res_s3.pixel_x = ctx_s3.pix_x;
			res_s3.pixel_y = ctx_s3.row;
			res_s3.on_wall = on_s3;
			res_s3.color   = on_s3 ? rdata : '0;
		end
	end

	// ------------------------------------------------------------------
	// Output register with a one-word skid register behind it. When the sink
	// stalls, the word already leaving the pipeline parks in the skid
	// register and only then does the pipeline stop.
	// ------------------------------------------------------------------
	logic ov_q;
	logic sv_q;
	res_t od_q;
	res_t sd_q;
	logic out_busy;

	assign adv      = !sv_q;
	assign out_busy = ov_q && !out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (out_busy) begin
			if (adv && v_s3) begin
				sv_q <= 1'b1;
			end
		end else if (sv_q) begin
			ov_q <= 1'b1;
			sv_q <= 1'b0;
		end else begin
			ov_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_busy) begin
			if (adv && v_s3) begin
				sd_q <= res_s3;
			end
		end else if (sv_q) begin
			od_q <= sd_q;
		end else begin
			od_q <= res_s3;
		end
	end

	assign out_ch.valid   = ov_q;
	assign out_ch.pixel_x = od_q.pixel_x;
	assign out_ch.pixel_y = od_q.pixel_y;
	assign out_ch.on_wall = od_q.on_wall;
	assign out_ch.color   = od_q.color;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	// The skid register only fills behind a word held in the output register.
	`TWS_ASSERT_IMP(a_skid_behind_out, sv_q, ov_q)
	// A parked word moves to the output as soon as the sink takes the current one.
	`TWS_ASSERT_NXT(a_skid_drains, sv_q && out_ch.ready, ov_q && !sv_q)
	// An off-wall or load word never carries a color.
	`TWS_ASSERT_IMP(a_color_off_wall, ov_q && !od_q.on_wall, od_q.color == '0)

endmodule

// ===== bench/textured_wall_column_shader_tb.sv =====
// ----------------------------------------------------------------------------
// textured_wall_column_shader_tb
// Self-checking bench for the textured wall column shader. Texel loads and
// pixel shade words go in through a random-stalling driver. Each accepted word
// is run through a local model of the slice height, texture step and texel
// lookup. Each pixel word that comes out is checked against the oldest
// prediction. The texture sizes are swept over several settings, extremes
// included. Any texel that a shade word would read is loaded first.
// ----------------------------------------------------------------------------
module textured_wall_column_shader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tws_pkg::*;

	// Fields of one input word as the bench builds it.
	typedef struct {
		op_t                op;
		logic [DIST_W-1:0]  ray_distance;
		side_t              wall_side;
		logic [HIT_W-1:0]   hit_coord;
		logic [RAY_W-1:0]   ray_num;
		logic [COFF_W-1:0]  column_offset;
		logic [ROW_W-1:0]   screen_row;
		logic [SIDE_W-1:0]  load_side;
		logic [LCOL_W-1:0]  load_col;
		logic [LROW_W-1:0]  load_row;
		logic [COLOR_W-1:0] load_value;
	} shade_word_t;

	// Register indexes: widths first, then heights, one per side.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_BASE = 3'(CFG_HEIGHT_BASE);
	localparam int PIPE_DRAIN = 60;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	tws_in_if in_ch();
	tws_out_if out_ch();

	textured_wall_column_shader dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Model state: the size registers and the texel store as the block holds them.
	logic [CFG_W-1:0] tex_size[8];
	logic [COLOR_W-1:0] texel_mem[STORE_DEPTH];
	// Texels that the stimulus has already loaded, so no unwritten entry is read.
	bit texel_loaded[STORE_DEPTH];

	shade_word_t pending_words[$];
	res_t expected_pixels[$];
	shade_word_t cur_word;
	bit in_busy;
	bit calm;
	int mismatches;

	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	// Clamp a texel index to the texture size, a size of zero acting as one.
	function automatic longint unsigned texel_clamp(longint unsigned v, logic [CFG_W-1:0] size);
		longint unsigned lim;
		lim = (size == '0) ? 1 : size;
		if (lim > TEX_DIM) begin
			lim = TEX_DIM;
		end
		return (v >= lim) ? lim - 1 : v;
	endfunction

	// Geometry of one shade word: screen position, whether the row is on the
	// wall, and which store entry holds its texel. Color is left at zero.
	function automatic void shade_geometry(input shade_word_t w, output res_t r,
			output int addr);
		longint unsigned full, ray_len, lh, step, soff, loff, y0, y1, iv, c, tcol, trow;
		logic [CFG_W-1:0] tw, th;
		full = longint'(SCREEN_HEIGHT) << FRAC;
		tw = tex_size[w.wall_side];
		th = tex_size[CFG_HEIGHT_BASE + w.wall_side];
		ray_len = (w.ray_distance == '0) ? 1 : w.ray_distance;
		lh = ((longint'(CELL_SIZE) * SCREEN_HEIGHT) << 16) / ray_len;
		// The step is taken from the height before it is clamped to the screen.
		step = (lh == 0) ? 64'hFFFF_FFFF : (longint'(th) << 16) / lh;
		soff = 0;
		if (lh > full) begin
			soff = (lh - full) >> 1;
			lh = full;
		end
		loff = (full >> 1) - (lh >> 1);
		y0 = 1 + (loff >> FRAC);
		y1 = 1 + ((lh + loff) >> FRAC);
		r = '0;
		addr = 0;
		r.pixel_x = PX_W'(w.ray_num * (SCREEN_WIDTH / RAY_COUNT) + w.column_offset);
		r.pixel_y = w.screen_row;
		if (w.screen_row >= y0 && w.screen_row <= y1) begin
			iv = (64'd1 << FRAC) + ((soff * step) >> FRAC) + (w.screen_row - y0) * step;
			trow = texel_clamp(iv >> FRAC, th);
			c = w.hit_coord % CELL_SIZE;
			// South and west faces run the texture the other way round.
			if (w.wall_side == SIDE_SOUTH || w.wall_side == SIDE_WEST) begin
				c = CELL_SIZE - 1 - c;
			end
			tcol = texel_clamp(c * tw / CELL_SIZE, tw);
			r.on_wall = 1'b1;
			addr = int'(w.wall_side) * TEX_DIM * TEX_DIM + int'(tcol) * TEX_DIM + int'(trow);
		end
	endfunction

	function automatic shade_word_t blank_word();
		shade_word_t w;
		w.op = OP_SHADE;
		w.ray_distance = '0;
		w.wall_side = SIDE_NORTH;
		w.hit_coord = '0;
		w.ray_num = '0;
		w.column_offset = '0;
		w.screen_row = '0;
		w.load_side = '0;
		w.load_col = '0;
		w.load_row = '0;
		w.load_value = '0;
		return w;
	endfunction

	// Random payload in every field but the operation, so unused fields also toggle.
	function automatic shade_word_t noisy_word();
		shade_word_t w;
		w = blank_word();
		w.ray_distance = DIST_W'($urandom);
		w.wall_side = side_t'($urandom_range(0, 3));
		w.hit_coord = HIT_W'($urandom);
		w.ray_num = RAY_W'($urandom);
		w.column_offset = COFF_W'($urandom);
		w.screen_row = ROW_W'($urandom);
		w.load_side = SIDE_W'($urandom);
		w.load_col = LCOL_W'($urandom);
		w.load_row = LROW_W'($urandom);
		w.load_value = $urandom;
		return w;
	endfunction

	function automatic void queue_load(shade_word_t w);
		w.op = OP_LOAD;
		texel_loaded[int'(w.load_side) * TEX_DIM * TEX_DIM + int'(w.load_col) * TEX_DIM
			+ int'(w.load_row)] = 1'b1;
		pending_words.push_back(w);
	endfunction

	// Queue a shade word; if it would hit a texel never loaded, load that texel first.
	function automatic void queue_shade(shade_word_t w);
		res_t r;
		int addr;
		shade_word_t ld;
		w.op = OP_SHADE;
		shade_geometry(w, r, addr);
		if (r.on_wall && !texel_loaded[addr]) begin
			ld = noisy_word();
			ld.load_side = SIDE_W'(addr / (TEX_DIM * TEX_DIM));
			ld.load_col = LCOL_W'((addr / TEX_DIM) % TEX_DIM);
			ld.load_row = LROW_W'(addr % TEX_DIM);
			queue_load(ld);
		end
		pending_words.push_back(w);
	endfunction

	// Mostly distances that give tall or screen-filling slices, so rows land on the wall.
	function automatic logic [DIST_W-1:0] pick_distance();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			return DIST_W'($urandom_range(0, 16383));
		end else if (roll < 80) begin
			return DIST_W'($urandom_range(16384, 262143));
		end
		return DIST_W'($urandom);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tex_size[idx] = value;
	endtask

	// Wait until every word is in and answered, then let the pipeline run dry.
	task automatic drain();
		while (pending_words.size() != 0 || in_busy || expected_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		shade_word_t w;
		repeat (count) begin
			w = noisy_word();
			if ($urandom_range(0, 99) < 20) begin
				queue_load(w);
			end else begin
				w.ray_distance = pick_distance();
				queue_shade(w);
			end
		end
	endtask

	// Stimulus: directed corner words, then random phases over several size settings.
	initial begin
		shade_word_t w;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = 1'b0;
		in_ch.ray_distance = '0;
		in_ch.wall_side = '0;
		in_ch.hit_coord = '0;
		in_ch.ray_num = '0;
		in_ch.column_offset = '0;
		in_ch.screen_row = '0;
		in_ch.load_side = '0;
		in_ch.load_col = '0;
		in_ch.load_row = '0;
		in_ch.load_value = '0;
		out_ch.ready = 1'b0;
		in_busy = 1'b0;
		calm = 1'b0;
		mismatches = 0;
		foreach (tex_size[i]) begin
			tex_size[i] = CFG_RESET;
		end
		foreach (texel_mem[i]) begin
			texel_mem[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: loads at the store corners, then shade words at the field extremes.
		w = blank_word();
		w.load_value = 32'hFFFF_FFFF;
		queue_load(w);
		w.load_side = 2'd3;
		w.load_col = 6'd63;
		w.load_row = 6'd63;
		w.load_value = 32'h0;
		queue_load(w);
		for (int s = 0; s < 4; s++) begin
			// Zero distance acts as the shortest one; the slice overfills the screen.
			w = blank_word();
			w.wall_side = side_t'(s);
			w.screen_row = ROW_W'(s * 170);
			w.hit_coord = (s % 2) ? 12'hFFF : 12'h000;
			queue_shade(w);
			// Longest distance: a thin slice around the middle row.
			w.ray_distance = '1;
			w.screen_row = ROW_W'(SCREEN_HEIGHT / 2 + s - 1);
			w.ray_num = 8'hFF;
			w.column_offset = 3'd7;
			queue_shade(w);
			// At full height and below with rows outside the slice, then a taller slice at the bottom row.
			w.ray_distance = DIST_W'(16384 + s * 40000);
			w.screen_row = (s % 2) ? 9'd511 : 9'd0;
			queue_shade(w);
			w.ray_distance = 20'd128;
			w.screen_row = 9'd511;
			w.column_offset = 3'd4;
			queue_shade(w);
		end
		random_phase(110);
		drain();

		// Every register at its smallest legal value.
		for (int i = 0; i < 4; i++) begin
			write_reg(REG_WIDTH_BASE + 3'(i), 7'd1);
			write_reg(REG_HEIGHT_BASE + 3'(i), 7'd1);
		end
		random_phase(100);
		drain();

		// Largest encodable sizes saturate at the texture size; run without any idling.
		calm = 1'b1;
		for (int i = 0; i < 4; i++) begin
			write_reg(REG_WIDTH_BASE + 3'(i), 7'd127);
			write_reg(REG_HEIGHT_BASE + 3'(i), 7'd127);
		end
		random_phase(115);
		drain();
		calm = 1'b0;

		// A size of zero counts as one.
		for (int i = 0; i < 8; i++) begin
			write_reg(3'(i), 7'd0);
		end
		random_phase(95);
		drain();

		// Mixed sizes, then back to the upper legal bound.
		repeat (2) begin
			for (int i = 0; i < 8; i++) begin
				write_reg(3'(i), CFG_W'($urandom_range(1, 64)));
			end
			random_phase(100);
			drain();
		end
		for (int i = 0; i < 8; i++) begin
			write_reg(3'(i), 7'd64);
		end
		random_phase(80);
		drain();

		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Driver: a new word goes out at the falling edge once the last one was taken.
	always @(negedge clk) begin
		if (arst_n && !in_busy) begin
			if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
				cur_word = pending_words.pop_front();
				in_ch.op <= cur_word.op;
				in_ch.ray_distance <= cur_word.ray_distance;
				in_ch.wall_side <= cur_word.wall_side;
				in_ch.hit_coord <= cur_word.hit_coord;
				in_ch.ray_num <= cur_word.ray_num;
				in_ch.column_offset <= cur_word.column_offset;
				in_ch.screen_row <= cur_word.screen_row;
				in_ch.load_side <= cur_word.load_side;
				in_ch.load_col <= cur_word.load_col;
				in_ch.load_row <= cur_word.load_row;
				in_ch.load_value <= cur_word.load_value;
				in_ch.valid <= 1'b1;
				in_busy = 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random as well, except in the calm phase.
	always @(negedge clk) begin
		if (arst_n) begin
			out_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
		end
	end

	// An accepted word updates the model and queues the pixel it should produce.
	always @(posedge clk) begin
		res_t r;
		int addr;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (cur_word.op == OP_LOAD) begin
				texel_mem[int'(cur_word.load_side) * TEX_DIM * TEX_DIM
					+ int'(cur_word.load_col) * TEX_DIM + int'(cur_word.load_row)]
					= cur_word.load_value;
				r = '0;
			end else begin
				shade_geometry(cur_word, r, addr);
				if (r.on_wall) begin
					r.color = texel_mem[addr];
				end
			end
			expected_pixels.push_back(r);
			in_busy = 1'b0;
		end
	end

	// Monitor: each pixel word is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: pixel word with nothing pending: x=%0d y=%0d", $realtime,
						out_ch.pixel_x, out_ch.pixel_y);
				end
			end else begin
				want = expected_pixels.pop_front();
				if (out_ch.pixel_x !== want.pixel_x || out_ch.pixel_y !== want.pixel_y
						|| out_ch.on_wall !== want.on_wall || out_ch.color !== want.color) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: expected x=%0d y=%0d wall=%0b color=%h, got x=%0d y=%0d wall=%0b color=%h",
							$realtime, want.pixel_x, want.pixel_y, want.on_wall, want.color,
							out_ch.pixel_x, out_ch.pixel_y, out_ch.on_wall, out_ch.color);
					end
				end
			end
		end
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== textured_wall_column_shader.f =====
+incdir+src
src/tws_pkg.sv
src/tws_in_if.sv
src/tws_out_if.sv
src/tws_ram.sv
src/tws_lh_div.sv
src/tws_step_div.sv
src/textured_wall_column_shader.sv
bench/textured_wall_column_shader_tb.sv
